// ----- hdl/dsss_pkg.sv -----
package dsss_pkg;

   // stroke modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_HOLD    = 2'd2;
   localparam logic [1:0] MODE_BACK    = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_STEPS   = 2'd2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd20;
   localparam logic [15:0] STEP_PERIOD_RST    = 16'd1;
   localparam logic [7:0]  TRAVEL_STEPS_RST   = 8'd50;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 16;

   typedef struct packed {
      logic       settled_level;
      logic [7:0] step_position;
      logic [1:0] stroke_mode;
      logic [3:0] coil_pattern;
   } rsp_fields_type;

   // one-hot wave-drive phase for a step index
   function automatic logic [3:0] phase_bits(input logic [7:0] idx);
      logic [3:0] bits;
      bits = 4'b0001 << idx[1:0];
      return bits;
   endfunction

endpackage

// ----- hdl/debounced_stepper_stroke_sequencer_unit.sv -----
// Stepper stroke sequencer with button debounce. Each req item is one tick
// carrying the raw active-low button level; each tick yields exactly one rsp
// item showing coil pattern, stroke mode, step position and debounced level
// after that tick. A debounced press runs travel_steps one-hot wave-drive
// steps forward, holds while the raw button stays pressed, then steps back.
// One item is accepted per clock: the tick's state update and result are
// computed combinationally into the state and result registers, and the result
// register is refilled in the same cycle it is taken, so req_tready only
// drops while a result waits on a stalled rsp side. Configuration writes take
// effect at once and are meant to happen while the block is idle.
module debounced_stepper_stroke_sequencer_unit
   import dsss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [0] button_raw, [7:1] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] coil_pattern, [5:4] stroke_mode,
                                               // [13:6] step_position, [14] settled_level,
                                               // [15] zero
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]  debounce_ticks_ff;
   logic [15:0] step_period_ff;
   logic [7:0]  travel_steps_ff;

   logic        previous_raw_ff, previous_raw_in;
   logic        settled_ff, settled_in;
   logic [7:0]  stable_count_ff, stable_count_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  step_index_ff, step_index_in;
   logic [15:0] dwell_count_ff, dwell_count_in;
   logic [3:0]  coils_ff, coils_in;

   logic           rsp_valid_ff;
   rsp_fields_type rsp_data_ff;

   logic        accept;
   logic        raw;
   logic [7:0]  travel_eff;
   logic [15:0] dwell_inc;
   logic        dwell_done;
   logic [7:0]  index_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_TICKS_RST;
         step_period_ff    <= STEP_PERIOD_RST;
         travel_steps_ff   <= TRAVEL_STEPS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata[7:0];
            CSR_STEP_PERIOD:    step_period_ff    <= csr_wdata[15:0];
            CSR_TRAVEL_STEPS:   travel_steps_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign raw        = req_tdata[0];

   assign travel_eff = (travel_steps_ff == 8'd0) ? 8'd1 : travel_steps_ff;
   assign dwell_inc  = dwell_count_ff + 16'd1;
   assign dwell_done = (dwell_inc >= step_period_ff);
   assign index_inc  = step_index_ff + 8'd1;

   always_comb begin
      previous_raw_in = previous_raw_ff;
      settled_in      = settled_ff;
      stable_count_in = stable_count_ff;
      mode_in         = mode_ff;
      step_index_in   = step_index_ff;
      dwell_count_in  = dwell_count_ff;
      coils_in        = coils_ff;

      unique case (mode_ff)
         MODE_IDLE: begin
            if (raw != previous_raw_ff) begin
               stable_count_in = 8'd0;
            end else if (stable_count_ff != COUNT_MAX) begin
               stable_count_in = stable_count_ff + 8'd1;
            end
            if (stable_count_in > debounce_ticks_ff && raw != settled_ff) begin
               settled_in = raw;
               if (!raw) begin
                  mode_in        = MODE_FORWARD;
                  step_index_in  = 8'd0;
                  dwell_count_in = 16'd0;
                  coils_in       = phase_bits(8'd0);
               end
            end
            previous_raw_in = raw;
         end
         MODE_FORWARD: begin
            dwell_count_in = dwell_done ? 16'd0 : dwell_inc;
            if (dwell_done) begin
               // index stays put when the end of travel is reached
               if (index_inc >= travel_eff) begin
                  mode_in = MODE_HOLD;
               end else begin
                  step_index_in = index_inc;
                  coils_in      = phase_bits(index_inc);
               end
            end
         end
         MODE_HOLD: begin
            if (raw) begin
               mode_in        = MODE_BACK;
               step_index_in  = travel_eff;
               dwell_count_in = 16'd0;
               coils_in       = phase_bits(travel_eff);
            end
         end
         MODE_BACK: begin
            dwell_count_in = dwell_done ? 16'd0 : dwell_inc;
            if (dwell_done) begin
               if (step_index_ff <= 8'd1) begin
                  mode_in = MODE_IDLE;
               end else begin
                  step_index_in = step_index_ff - 8'd1;
                  coils_in      = phase_bits(step_index_in);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= 1'b1;
         settled_ff      <= 1'b0;
         stable_count_ff <= 8'd0;
         mode_ff         <= MODE_IDLE;
         step_index_ff   <= 8'd0;
         dwell_count_ff  <= 16'd0;
         coils_ff        <= 4'd0;
      end else if (accept) begin
         previous_raw_ff <= previous_raw_in;
         settled_ff      <= settled_in;
         stable_count_ff <= stable_count_in;
         mode_ff         <= mode_in;
         step_index_ff   <= step_index_in;
         dwell_count_ff  <= dwell_count_in;
         coils_ff        <= coils_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.coil_pattern  <= coils_in;
         rsp_data_ff.stroke_mode   <= mode_in;
         rsp_data_ff.step_position <= step_index_in;
         rsp_data_ff.settled_level <= settled_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   a_coils_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[3:0]))
      else $error("coil pattern not one-hot or zero");

   a_coils_track_index: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FORWARD || mode_ff == MODE_BACK) |->
         coils_ff == phase_bits(step_index_ff))
      else $error("coils out of step with step index while moving");

   a_state_holds_idle_side: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(mode_ff) && $stable(step_index_ff) && $stable(dwell_count_ff))
      else $error("stroke state moved without an accepted item");

   a_debounce_frozen: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff != MODE_IDLE) |=>
         $stable(stable_count_ff) && $stable(settled_ff) && $stable(previous_raw_ff))
      else $error("debounce state changed while a stroke is active");

endmodule
